// ===== rtl/core/sart_pkg.sv =====
// shared constants and codes for the sequence / ack / retransmit tracker
package sart_pkg;

  localparam int unsigned SEQ_FIRST    = 1;
  localparam int unsigned SEQ_LAST     = 1023;
  localparam int unsigned SEQ_NONE     = 0;
  localparam int unsigned ACK_INTERVAL = 16;
  localparam int unsigned RELEASE_SPAN = 16 * 100;

  localparam int unsigned SEQ_W  = 16;
  localparam int unsigned CNT_W  = 11;
  localparam int unsigned CMD_W  = 2;
  localparam int unsigned KIND_W = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_SEND   = 2'd0,
    CMD_RECV   = 2'd1,
    CMD_RESEND = 2'd2,
    CMD_SWEEP  = 2'd3
  } cmd_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_ASSIGNED = 3'd0,
    KIND_VERDICT  = 3'd1,
    KIND_HELD     = 3'd2,
    KIND_LOST     = 3'd3,
    KIND_SWEPT    = 3'd4
  } kind_t;

endpackage

// ===== rtl/core/sequence_ack_retransmit_tracker.sv =====
// sequence / ack / retransmit tracker: counters, held-mark table and sweep sequencer
//
// Input channel (in_*): one command per transfer; in_tuser carries the command
// (send, receive check, resend request, ack sweep), in_tdata the sequence number.
// Result channel (out_*): exactly one result transfer per command; out_tuser
// carries the result kind, out_tdata the numbers, flags and counts.
// Path from the accepting edge to the result being offered:
//   send and receive check: result registered at the accepting edge
//   resend request: one read of the held-mark memory, then the result is registered
//   ack sweep: HELD_DEPTH = SEQ_LAST + ACK_INTERVAL entries
//     (1039 at the defaults); the sweep walks the memory one entry a cycle
//     through its single read port and single write port
// Throughput: one command at a time; in_tready is high only when the sequencer
// is idle and the result register is empty or being emptied in that cycle.
// Reset: both counters return to SEQ_FIRST, then a clearing pass writes every
// entry of the held-mark memory (HELD_DEPTH entries, 1039 at the defaults)
// with in_tready low.
// A stalled receiver simply holds the result register; no new command is taken
// until that result has been transferred.
module sequence_ack_retransmit_tracker #(
  parameter int unsigned SEQ_FIRST    = sart_pkg::SEQ_FIRST,
  parameter int unsigned SEQ_LAST     = sart_pkg::SEQ_LAST,
  parameter int unsigned ACK_INTERVAL = sart_pkg::ACK_INTERVAL,
  parameter int unsigned RELEASE_SPAN = sart_pkg::RELEASE_SPAN
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,  // [15:0] packet_seq
  input  logic [1:0]  in_tuser,  // [1:0] cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata, // [15:0] seq_value, [16] accepted, [17] ack_valid,
                                 // [33:18] ack_count, [44:34] released_count,
                                 // [60:45] expected_next, [63:61] zero
  output logic [2:0]  out_tuser  // [2:0] kind
);

  localparam int unsigned SW         = sart_pkg::SEQ_W;
  localparam int unsigned NW         = sart_pkg::CNT_W;
  localparam int unsigned HELD_DEPTH = SEQ_LAST + ACK_INTERVAL;
  localparam int unsigned AW         = $clog2(HELD_DEPTH);
  localparam int unsigned CW         = AW + 1;
  localparam int unsigned RW         = $clog2(ACK_INTERVAL);
  localparam logic [RW-1:0] RES_FIRST = RW'(SEQ_FIRST % ACK_INTERVAL);
  localparam logic [RW-1:0] RES_LAST  = RW'(ACK_INTERVAL - 1);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RESEND,
    ST_SWEEP
  } st_t;

  typedef struct packed {
    logic [SW-1:0] nxt;
    logic [RW-1:0] res;
    logic          hit;
    logic [SW-1:0] raw;
  } adv_t;

  // counter step; residue tracks the value modulo ACK_INTERVAL
  function automatic adv_t advance(input logic [SW-1:0] cur, input logic [RW-1:0] res);
    adv_t          a;
    logic [SW:0]   raw;
    logic          wrap;
    raw   = {1'b0, cur} + (SW+1)'(1);
    a.hit = (res == RES_LAST);
    a.raw = raw[SW-1:0];
    wrap  = (a.hit && (raw > (SW+1)'(SEQ_LAST))) || raw[SW];
    if (wrap) begin
      a.nxt = SW'(SEQ_FIRST);
      a.res = RES_FIRST;
    end else begin
      a.nxt = raw[SW-1:0];
      a.res = a.hit ? '0 : res + RW'(1);
    end
    return a;
  endfunction

  // held-mark memory
  logic          mem [HELD_DEPTH];
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic          mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic          rd_data_r;

  st_t           state_r, state_nxt;
  logic [SW-1:0] send_next_r, send_next_nxt;
  logic [RW-1:0] send_res_r, send_res_nxt;
  logic [SW-1:0] recv_exp_r, recv_exp_nxt;
  logic [RW-1:0] recv_res_r, recv_res_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic          pend_r, pend_nxt;
  logic [AW-1:0] chk_idx_r, chk_idx_nxt;
  logic [NW-1:0] cnt_r, cnt_nxt;
  logic [SW-1:0] seq_r, seq_nxt;
  logic          in_range_r, in_range_nxt;

  logic          out_tvalid_r, out_tvalid_nxt;
  logic          out_load;
  logic [2:0]    out_kind_r, out_kind_nxt;
  logic [SW-1:0] out_seq_r, out_seq_nxt;
  logic          out_acc_r, out_acc_nxt;
  logic          out_ackv_r, out_ackv_nxt;
  logic [SW-1:0] out_ackc_r, out_ackc_nxt;
  logic [NW-1:0] out_rel_r, out_rel_nxt;
  logic [SW-1:0] out_exp_r, out_exp_nxt;

  logic          in_fire;
  logic [SW-1:0] in_seq;
  logic [SW:0]   in_seq_ext;
  logic [SW:0]   send_ext;
  logic [SW:0]   chk_ext;
  logic [SW:0]   seq_ext;
  logic [SW:0]   behind;
  logic          release_hit;
  adv_t          send_adv;
  adv_t          recv_adv;

  assign in_tready  = (state_r == ST_IDLE) && (!out_tvalid_r || out_tready);
  assign in_fire    = in_tvalid && in_tready;
  assign in_seq     = in_tdata[SW-1:0];
  assign in_seq_ext = {1'b0, in_seq};
  assign send_ext   = {1'b0, send_next_r};
  assign chk_ext    = (SW+1)'(chk_idx_r);
  assign seq_ext    = {1'b0, seq_r};
  assign behind     = seq_ext - chk_ext;
  assign release_hit = rd_data_r && (seq_ext > chk_ext) &&
                       (behind < (SW+1)'(RELEASE_SPAN));
  assign send_adv   = advance(send_next_r, send_res_r);
  assign recv_adv   = advance(recv_exp_r, recv_res_r);

  always_comb begin
    state_nxt     = state_r;
    send_next_nxt = send_next_r;
    send_res_nxt  = send_res_r;
    recv_exp_nxt  = recv_exp_r;
    recv_res_nxt  = recv_res_r;
    idx_nxt       = idx_r;
    pend_nxt      = 1'b0;
    chk_idx_nxt   = chk_idx_r;
    cnt_nxt       = cnt_r;
    seq_nxt       = seq_r;
    in_range_nxt  = in_range_r;
    mem_we        = 1'b0;
    mem_waddr     = chk_idx_r;
    mem_wdata     = 1'b0;
    mem_re        = 1'b0;
    mem_raddr     = idx_r[AW-1:0];
    out_load      = 1'b0;
    out_kind_nxt  = sart_pkg::KIND_VERDICT;
    out_seq_nxt   = '0;
    out_acc_nxt   = 1'b0;
    out_ackv_nxt  = 1'b0;
    out_ackc_nxt  = '0;
    out_rel_nxt   = '0;
    out_exp_nxt   = recv_exp_r;

    case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r[AW-1:0];
        mem_wdata = 1'b0;
        if (idx_r == CW'(HELD_DEPTH - 1)) begin
          idx_nxt   = '0;
          state_nxt = ST_IDLE;
        end else begin
          idx_nxt = idx_r + CW'(1);
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          case (sart_pkg::cmd_t'(in_tuser))
            sart_pkg::CMD_SEND: begin
              out_load     = 1'b1;
              out_kind_nxt = sart_pkg::KIND_ASSIGNED;
              out_seq_nxt  = send_next_r;
              if (send_ext < (SW+1)'(HELD_DEPTH)) begin
                mem_we    = 1'b1;
                mem_waddr = send_ext[AW-1:0];
                mem_wdata = 1'b1;
              end
              send_next_nxt = send_adv.nxt;
              send_res_nxt  = send_adv.res;
            end
            sart_pkg::CMD_RECV: begin
              out_load     = 1'b1;
              out_kind_nxt = sart_pkg::KIND_VERDICT;
              if (in_seq == SW'(sart_pkg::SEQ_NONE)) begin
                out_acc_nxt = 1'b1;
              end else if (in_seq == recv_exp_r) begin
                out_acc_nxt  = 1'b1;
                recv_exp_nxt = recv_adv.nxt;
                recv_res_nxt = recv_adv.res;
                out_exp_nxt  = recv_adv.nxt;
                if (recv_adv.hit) begin
                  out_ackv_nxt = 1'b1;
                  out_ackc_nxt = recv_adv.raw;
                end
              end
            end
            sart_pkg::CMD_RESEND: begin
              seq_nxt      = in_seq;
              in_range_nxt = in_seq_ext < (SW+1)'(HELD_DEPTH);
              mem_re       = 1'b1;
              mem_raddr    = in_seq_ext[AW-1:0];
              state_nxt    = ST_RESEND;
            end
            sart_pkg::CMD_SWEEP: begin
              seq_nxt   = in_seq;
              idx_nxt   = '0;
              cnt_nxt   = '0;
              state_nxt = ST_SWEEP;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_RESEND: begin
        out_load     = 1'b1;
        out_kind_nxt = (in_range_r && rd_data_r) ? sart_pkg::KIND_HELD
                                                 : sart_pkg::KIND_LOST;
        out_seq_nxt  = seq_r;
        state_nxt    = ST_IDLE;
      end
      ST_SWEEP: begin
        // read entry idx while the entry read last cycle is checked and, if released, cleared
        if (pend_r && release_hit) begin
          mem_we    = 1'b1;
          mem_waddr = chk_idx_r;
          mem_wdata = 1'b0;
          cnt_nxt   = cnt_r + NW'(1);
        end
        if (idx_r == CW'(HELD_DEPTH)) begin
          out_load     = 1'b1;
          out_kind_nxt = sart_pkg::KIND_SWEPT;
          out_rel_nxt  = cnt_nxt;
          idx_nxt      = '0;
          state_nxt    = ST_IDLE;
        end else begin
          mem_re      = 1'b1;
          mem_raddr   = idx_r[AW-1:0];
          chk_idx_nxt = idx_r[AW-1:0];
          pend_nxt    = 1'b1;
          idx_nxt     = idx_r + CW'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    out_tvalid_nxt = out_load || (out_tvalid_r && !out_tready);
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      send_next_r  <= SW'(SEQ_FIRST);
      send_res_r   <= RES_FIRST;
      recv_exp_r   <= SW'(SEQ_FIRST);
      recv_res_r   <= RES_FIRST;
      idx_r        <= '0;
      pend_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      send_next_r  <= send_next_nxt;
      send_res_r   <= send_res_nxt;
      recv_exp_r   <= recv_exp_nxt;
      recv_res_r   <= recv_res_nxt;
      idx_r        <= idx_nxt;
      pend_r       <= pend_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chk_idx_r  <= chk_idx_nxt;
    cnt_r      <= cnt_nxt;
    seq_r      <= seq_nxt;
    in_range_r <= in_range_nxt;
    if (out_load) begin
      out_kind_r <= out_kind_nxt;
      out_seq_r  <= out_seq_nxt;
      out_acc_r  <= out_acc_nxt;
      out_ackv_r <= out_ackv_nxt;
      out_ackc_r <= out_ackc_nxt;
      out_rel_r  <= out_rel_nxt;
      out_exp_r  <= out_exp_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {3'b000, out_exp_r, out_rel_r, out_ackc_r, out_ackv_r, out_acc_r,
                       out_seq_r};

endmodule
